@@ src/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the countdown sequence timer
// Opcodes, fixed field widths, and the command/status/result structs that
// pass between controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

	// fixed field widths
	localparam int OP_W    = 3;
	localparam int IDX_W   = 3;
	localparam int TBL_D_W = 16;  // overflow and tick table entries
	localparam int CFG_W   = 4;   // countdown_count
	localparam int PASS_W  = 16;  // passed overflow counter

	// opcodes
	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
	localparam logic [OP_W-1:0] OP_START = 3'd2;
	localparam logic [OP_W-1:0] OP_RESET = 3'd3;
	localparam logic [OP_W-1:0] OP_TAKE  = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic capture;     // register the result of this transaction
		logic accepted;
		logic cnt_inc;
		logic cnt_clr;
		logic pass_inc;
		logic pass_clr;
		logic entry_zero;
		logic entry_next;
		logic load_wr;
		logic tables_clr;
		logic fire;
		logic done;
		logic busy;
		logic take;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ovf_zero;    // current entry has no overflow phase
		logic wrap;        // next tick wraps the counter
		logic ovf_done;    // next wrap reaches the overflow count
		logic target_hit;  // next tick reaches the tick target
		logic last;        // current entry is the last of the sequence
		logic start_ok;
		logic load_ok;
	} sts_t;

	// result payload
	typedef struct packed {
		logic             accepted;
		logic             fired;
		logic [IDX_W-1:0] fired_index;
		logic             fired_deferred;
		logic             sequence_done;
		logic             busy_res;
		logic             pending_valid;
		logic [IDX_W-1:0] pending_index;
	} res_t;

endpackage

`default_nettype wire

@@ src/cst_if.sv @@
// ----------------------------------------------------------------------------
// cst_if: channel interfaces of the countdown sequence timer
// Item input, result output and configuration write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_item_if;
	import cst_pkg::*;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [IDX_W-1:0]   entry_index;
	logic [TBL_D_W-1:0] load_overflows;
	logic [TBL_D_W-1:0] load_ticks;
	logic               load_deferred;

	modport source (output valid, opcode, entry_index, load_overflows, load_ticks,
		load_deferred, input ready);
	modport sink (input valid, opcode, entry_index, load_overflows, load_ticks,
		load_deferred, output ready);
endinterface

interface cst_res_if;
	import cst_pkg::*;
	logic             valid;
	logic             ready;
	logic             accepted;
	logic             fired;
	logic [IDX_W-1:0] fired_index;
	logic             fired_deferred;
	logic             sequence_done;
	logic             busy_res;
	logic             pending_valid;
	logic [IDX_W-1:0] pending_index;

	modport source (output valid, accepted, fired, fired_index, fired_deferred,
		sequence_done, busy_res, pending_valid, pending_index, input ready);
	modport sink (input valid, accepted, fired, fired_index, fired_deferred,
		sequence_done, busy_res, pending_valid, pending_index, output ready);
endinterface

interface cst_cfg_if;
	import cst_pkg::*;
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] countdown_count;

	modport source (output valid, countdown_count, input ready);
	modport sink (input valid, countdown_count, output ready);
endinterface

`default_nettype wire

@@ src/cst_ctl.sv @@
// ----------------------------------------------------------------------------
// cst_ctl: controller of the countdown sequence timer
// Tracks the sequence phase (idle, overflow wraps, tick count), decodes each
// transaction into datapath commands and owns the output valid register.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_ctl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	input  logic [cst_pkg::OP_W-1:0] opcode,
	input  logic                     res_ready,
	input  cst_pkg::sts_t            sts,
	output logic                     item_ready,
	output logic                     res_valid,
	output cst_pkg::cmd_t            cmd
);
	import cst_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_WRAP, ST_COUNT} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   acc;

	// output register frees up as soon as it is taken
	assign item_ready = !res_valid_q || res_ready;
	assign acc        = item_valid && item_ready;
	assign res_valid  = res_valid_q;

	// command decode and next phase
	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.capture  = acc;
		cmd.accepted = 1'b1;
		if (acc) begin
			case (opcode)
				OP_TICK: begin
					if (state_q != ST_IDLE) begin
						cmd.cnt_inc = 1'b1;
						// an entry without overflows counts ticks right away
						if (state_q == ST_COUNT || sts.ovf_zero) begin
							if (sts.target_hit) begin
								cmd.fire     = 1'b1;
								cmd.cnt_clr  = 1'b1;
								cmd.pass_clr = 1'b1;
								if (sts.last) begin
									cmd.done       = 1'b1;
									cmd.entry_zero = 1'b1;
									state_d        = ST_IDLE;
								end else begin
									cmd.entry_next = 1'b1;
									state_d        = ST_WRAP;
								end
							end
						end else if (sts.wrap) begin
							cmd.pass_inc = 1'b1;
							if (sts.ovf_done) begin
								state_d = ST_COUNT;
							end
						end
					end
				end
				OP_LOAD: begin
					if (state_q == ST_IDLE && sts.load_ok) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.accepted = 1'b0;
					end
				end
				OP_START: begin
					if (state_q == ST_IDLE && sts.start_ok) begin
						cmd.entry_zero = 1'b1;
						cmd.cnt_clr    = 1'b1;
						cmd.pass_clr   = 1'b1;
						state_d        = ST_WRAP;
					end else begin
						cmd.accepted = 1'b0;
					end
				end
				OP_RESET: begin
					cmd.tables_clr = 1'b1;
					cmd.entry_zero = 1'b1;
					cmd.cnt_clr    = 1'b1;
					cmd.pass_clr   = 1'b1;
					state_d        = ST_IDLE;
				end
				OP_TAKE: begin
					cmd.take = 1'b1;
				end
				default: begin
				end
			endcase
		end
		cmd.busy = (state_d != ST_IDLE);
	end

	// phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/cst_dp.sv @@
// ----------------------------------------------------------------------------
// cst_dp: datapath of the countdown sequence timer
// Entry tables, tick and overflow counters, entry pointer, pending event,
// countdown_count register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_dp #(
	parameter int MAX_ENTRIES  = 8,
	parameter int COUNTER_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cst_pkg::cmd_t               cmd,
	input  logic [cst_pkg::IDX_W-1:0]   entry_index,
	input  logic [cst_pkg::TBL_D_W-1:0] load_overflows,
	input  logic [cst_pkg::TBL_D_W-1:0] load_ticks,
	input  logic                        load_deferred,
	input  logic                        cfg_we,
	input  logic [cst_pkg::CFG_W-1:0]   cfg_data,
	output cst_pkg::sts_t               sts,
	output cst_pkg::res_t               result
);
	import cst_pkg::*;

	localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NXT_W   = ENTRY_W + 1;
	localparam int CMP_W   = (NXT_W > CFG_W) ? NXT_W : CFG_W;
	// only indexes below eight can be loaded; higher entries keep reset values
	localparam int TBL_N   = (MAX_ENTRIES < 8) ? MAX_ENTRIES : 8;
	localparam int TBL_W   = (TBL_N > 1) ? $clog2(TBL_N) : 1;
	localparam int EXT_W   = 32;

	logic [TBL_D_W-1:0]      ovf_q [TBL_N];
	logic [TBL_D_W-1:0]      tick_q [TBL_N];
	logic [TBL_N-1:0]        def_q;
	logic [ENTRY_W-1:0]      entry_q;
	logic [COUNTER_BITS-1:0] cnt_q;
	logic [PASS_W-1:0]       pass_q;
	logic [CFG_W-1:0]        count_q;
	logic                    pend_q;
	logic [IDX_W-1:0]        pend_idx_q;
	res_t                    res_q;

	logic                    in_tbl;
	logic [TBL_D_W-1:0]      ovf_rd;
	logic [TBL_D_W-1:0]      tick_rd;
	logic                    def_rd;
	logic [COUNTER_BITS-1:0] cnt_inc;
	logic [COUNTER_BITS-1:0] tgt_m;
	logic [COUNTER_BITS-1:0] target;
	logic [PASS_W-1:0]       pass_inc;
	logic [NXT_W-1:0]        next_e;
	logic [IDX_W-1:0]        e3;
	logic [EXT_W-1:0]        tick_ext;
	logic [6:0]              e_ext;

	// current entry lookup
	assign in_tbl  = CMP_W'(entry_q) < CMP_W'(TBL_N);
	assign ovf_rd  = in_tbl ? ovf_q[entry_q[TBL_W-1:0]] : '0;
	assign tick_rd = in_tbl ? tick_q[entry_q[TBL_W-1:0]] : '0;
	assign def_rd  = in_tbl ? def_q[entry_q[TBL_W-1:0]] : 1'b1;
	assign e_ext   = 7'(entry_q);
	assign e3      = e_ext[IDX_W-1:0];

	// counter compares; a masked target of zero counts as one
	assign cnt_inc  = cnt_q + 1'b1;
	assign pass_inc = pass_q + 1'b1;
	assign tick_ext = EXT_W'(tick_rd);
	assign tgt_m    = tick_ext[COUNTER_BITS-1:0];
	assign target   = (tgt_m == '0) ? COUNTER_BITS'(1) : tgt_m;
	assign next_e   = NXT_W'(entry_q) + 1'b1;

	assign sts.ovf_zero   = (ovf_rd == '0);
	assign sts.wrap       = &cnt_q;
	assign sts.ovf_done   = (pass_inc >= ovf_rd);
	assign sts.target_hit = (cnt_inc == target);
	assign sts.last       = (CMP_W'(next_e) >= CMP_W'(count_q)) ||
		(CMP_W'(next_e) >= CMP_W'(MAX_ENTRIES));
	assign sts.start_ok   = (count_q != '0) && (CMP_W'(count_q) <= CMP_W'(MAX_ENTRIES));
	assign sts.load_ok    = CMP_W'(entry_index) < CMP_W'(MAX_ENTRIES);

	assign result = res_q;

	// entry tables
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TBL_N; i++) begin
				ovf_q[i]  <= '0;
				tick_q[i] <= '0;
			end
			def_q <= '1;
		end else if (cmd.tables_clr) begin
			for (int i = 0; i < TBL_N; i++) begin
				ovf_q[i]  <= '0;
				tick_q[i] <= '0;
			end
		end else if (cmd.load_wr) begin
			ovf_q[entry_index[TBL_W-1:0]]  <= load_overflows;
			tick_q[entry_index[TBL_W-1:0]] <= load_ticks;
			def_q[entry_index[TBL_W-1:0]]  <= load_deferred;
		end
	end

	// counters, entry pointer, count register, pending event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			pass_q     <= '0;
			entry_q    <= '0;
			count_q    <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_inc;
			end
			if (cmd.pass_clr) begin
				pass_q <= '0;
			end else if (cmd.pass_inc) begin
				pass_q <= pass_inc;
			end
			if (cmd.entry_zero) begin
				entry_q <= '0;
			end else if (cmd.entry_next) begin
				entry_q <= next_e[ENTRY_W-1:0];
			end
			if (cmd.tables_clr) begin
				count_q <= '0;
			end else if (cfg_we) begin
				count_q <= cfg_data;
			end
			// newer deferred firing overwrites the waiting one
			if (cmd.tables_clr || cmd.take) begin
				pend_q     <= 1'b0;
				pend_idx_q <= '0;
			end else if (cmd.fire && def_rd) begin
				pend_q     <= 1'b1;
				pend_idx_q <= e3;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_q.accepted       <= cmd.accepted;
			res_q.fired          <= cmd.fire;
			res_q.fired_index    <= cmd.fire ? e3 : '0;
			res_q.fired_deferred <= cmd.fire && def_rd;
			res_q.sequence_done  <= cmd.done;
			res_q.busy_res       <= cmd.busy;
			res_q.pending_valid  <= cmd.take && pend_q;
			res_q.pending_index  <= (cmd.take && pend_q) ? pend_idx_q : '0;
		end
	end

endmodule

`default_nettype wire

@@ src/countdown_sequence_timer_top.sv @@
// ----------------------------------------------------------------------------
// countdown_sequence_timer_top: table-driven countdown sequence timer
// Runs loaded entries one after another: overflow wraps, then ticks to the
// target, then fires (reported, and latched as pending if deferred) and advances.
//
//   channel  dir  handshake     payload
//   item     in   valid/ready   opcode, entry_index, load_*
//   res      out  valid/ready   accepted, fired*, sequence_done, busy_res,
//                               pending_valid, pending_index
//   cfg      in   valid/ready   countdown_count (always ready)
//
// Every transaction is decoded and executed in the cycle it is accepted; its result sits in
// the output register the next cycle, one transaction per clock sustained.
// A stalled result blocks the next transaction only while the result register
// is full and not taken. Reset clears all control state and tables at once.
// ----------------------------------------------------------------------------
`default_nettype none

module countdown_sequence_timer_top #(
	parameter int MAX_ENTRIES  = 8,
	parameter int COUNTER_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	cst_item_if.sink  item,
	cst_res_if.source res,
	cst_cfg_if.sink   cfg
);
	import cst_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t result;

	assign cfg.ready = 1'b1;

	cst_ctl u_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.opcode     (item.opcode),
		.res_ready  (res.ready),
		.sts        (sts),
		.item_ready (item.ready),
		.res_valid  (res.valid),
		.cmd        (cmd)
	);

	cst_dp #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.entry_index    (item.entry_index),
		.load_overflows (item.load_overflows),
		.load_ticks     (item.load_ticks),
		.load_deferred  (item.load_deferred),
		.cfg_we         (cfg.valid),
		.cfg_data       (cfg.countdown_count),
		.sts            (sts),
		.result         (result)
	);

	// result payload
	assign res.accepted       = result.accepted;
	assign res.fired          = result.fired;
	assign res.fired_index    = result.fired_index;
	assign res.fired_deferred = result.fired_deferred;
	assign res.sequence_done  = result.sequence_done;
	assign res.busy_res       = result.busy_res;
	assign res.pending_valid  = result.pending_valid;
	assign res.pending_index  = result.pending_index;

endmodule

`default_nettype wire

@@ src/cst_checker.sv @@
// ----------------------------------------------------------------------------
// cst_checker: port-level checks of the countdown sequence timer
// Watches the item and result channels and the consistency of result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       accepted,
	input logic       fired,
	input logic [2:0] fired_index,
	input logic       fired_deferred,
	input logic       sequence_done,
	input logic       busy_res,
	input logic       pending_valid,
	input logic [2:0] pending_index
);

	// every input transaction shows a result the next cycle
	a_item_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> res_valid)
		else $error("no result after input transaction");

	// a stalled result stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a firing comes from a tick: accepted, no take, done only when stopped
	a_fire_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fired |-> accepted && !pending_valid)
		else $error("firing result inconsistent");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && sequence_done |-> fired && !busy_res)
		else $error("sequence done without final firing");

	// index fields are zero when their flags are clear
	a_zero_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (fired || (fired_index == 3'd0 && !fired_deferred)) &&
		(pending_valid || pending_index == 3'd0))
		else $error("index field set without its flag");

endmodule

bind countdown_sequence_timer_top cst_checker u_cst_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.accepted       (res.accepted),
	.fired          (res.fired),
	.fired_index    (res.fired_index),
	.fired_deferred (res.fired_deferred),
	.sequence_done  (res.sequence_done),
	.busy_res       (res.busy_res),
	.pending_valid  (res.pending_valid),
	.pending_index  (res.pending_index)
);

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the countdown sequence timer
// A queue-fed driver sends timer commands over the item channel. A monitor
// predicts each result from its own model of the entry table and sequencer and
// checks every result field. Traffic runs in three idle/stall mixes. Random
// episodes of load/start/tick sequences are mixed with aborts and noise. A
// final back-to-back burst runs with the output held off for a while.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cst_pkg::*;

	localparam int MAX_ENTRIES  = 8;
	localparam int CNT_W        = 16;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int BURST_TICKS  = 40;

	// opcodes the block decodes as no-ops
	localparam logic [OP_W-1:0] OP_UNUSED5 = 3'd5;
	localparam logic [OP_W-1:0] OP_UNUSED6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [IDX_W-1:0]   idx;
		logic [TBL_D_W-1:0] ovf;
		logic [TBL_D_W-1:0] ticks;
		logic               defer;
	} timer_cmd_t;

	logic clk;
	logic arst_n;

	cst_item_if item_bus ();
	cst_res_if  res_bus ();
	cst_cfg_if  cfg_bus ();

	countdown_sequence_timer_top #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.COUNTER_BITS(CNT_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_bus),
		.res   (res_bus),
		.cfg   (cfg_bus)
	);

	timer_cmd_t cmd_backlog[$];
	res_t       expected_results[$];

	int errors         = 0;
	int items_queued   = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 33;
	int recv_idle_pct  = 78;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;
	logic item_hs;

	// timer model state
	logic [TBL_D_W-1:0] tbl_ovf   [MAX_ENTRIES];
	logic [TBL_D_W-1:0] tbl_ticks [MAX_ENTRIES];
	logic               tbl_defer [MAX_ENTRIES];
	logic               seq_running;
	logic [IDX_W-1:0]   seq_entry;
	logic               seq_tick_phase;
	logic [CNT_W-1:0]   seq_ticks;
	logic [PASS_W-1:0]  seq_passed;
	logic               evt_pending;
	logic [IDX_W-1:0]   evt_entry;
	logic [CFG_W-1:0]   seq_count;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Timer model
	// ------------------------------------------------------------------------

	// stop the sequence and clear the counters, tables optionally
	function automatic void clear_timer(input logic with_tables);
		if (with_tables) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				tbl_ovf[i]   = '0;
				tbl_ticks[i] = '0;
			end
			evt_pending = 1'b0;
			evt_entry   = '0;
			seq_count   = '0;
		end
		seq_running    = 1'b0;
		seq_entry      = '0;
		seq_tick_phase = 1'b0;
		seq_ticks      = '0;
		seq_passed     = '0;
	endfunction

	function automatic void enter_entry();
		seq_ticks      = '0;
		seq_passed     = '0;
		seq_tick_phase = (tbl_ovf[seq_entry] == '0);
	endfunction

	function automatic res_t predict_timer(input timer_cmd_t c);
		res_t             r;
		logic [CNT_W-1:0] target;
		logic [IDX_W:0]   nxt;
		r = '0;
		r.accepted = 1'b1;
		case (c.op)
			OP_TICK: begin
				if (seq_running) begin
					seq_ticks = seq_ticks + 1'b1;
					if (!seq_tick_phase) begin
						// overflow phase: count full wraps
						if (seq_ticks == '0) begin
							seq_passed = seq_passed + 1'b1;
							if (seq_passed >= tbl_ovf[seq_entry]) begin
								seq_tick_phase = 1'b1;
								seq_ticks      = '0;
							end
						end
					end else begin
						target = tbl_ticks[seq_entry];
						if (target == '0)
							target = CNT_W'(1);
						if (seq_ticks == target) begin
							r.fired          = 1'b1;
							r.fired_index    = seq_entry;
							r.fired_deferred = tbl_defer[seq_entry];
							if (tbl_defer[seq_entry]) begin
								evt_pending = 1'b1;
								evt_entry   = seq_entry;
							end
							nxt = {1'b0, seq_entry} + 1'b1;
							if (nxt >= seq_count || nxt >= MAX_ENTRIES) begin
								clear_timer(1'b0);
								r.sequence_done = 1'b1;
							end else begin
								seq_entry = nxt[IDX_W-1:0];
								enter_entry();
							end
						end
					end
				end
			end
			OP_LOAD: begin
				if (seq_running) begin
					r.accepted = 1'b0;
				end else begin
					tbl_ovf[c.idx]   = c.ovf;
					tbl_ticks[c.idx] = c.ticks;
					tbl_defer[c.idx] = c.defer;
				end
			end
			OP_START: begin
				if (seq_running || seq_count == '0 || seq_count > MAX_ENTRIES) begin
					r.accepted = 1'b0;
				end else begin
					seq_running = 1'b1;
					seq_entry   = '0;
					enter_entry();
				end
			end
			OP_RESET: begin
				clear_timer(1'b1);
			end
			OP_TAKE: begin
				if (evt_pending) begin
					r.pending_valid = 1'b1;
					r.pending_index = evt_entry;
				end
				evt_pending = 1'b0;
				evt_entry   = '0;
			end
			default: begin
			end
		endcase
		r.busy_res = seq_running;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Driver, receiver, monitor
	// ------------------------------------------------------------------------

	// item driver: hold until taken, then maybe idle, else next command
	always @(negedge clk) begin
		timer_cmd_t c;
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else if (!item_bus.valid || item_hs) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				c = cmd_backlog.pop_front();
				item_bus.valid          <= 1'b1;
				item_bus.opcode         <= c.op;
				item_bus.entry_index    <= c.idx;
				item_bus.load_overflows <= c.ovf;
				item_bus.load_ticks     <= c.ticks;
				item_bus.load_deferred  <= c.defer;
			end else begin
				item_bus.valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served   <= hold_requests;
			hold_left     <= HOLD_CYCLES;
			res_bus.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= 30)
				$display("%0t: mismatch %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// monitor: check results, then track config and predict new transactions
	always @(posedge clk) begin
		res_t       want;
		timer_cmd_t c;
		if (!arst_n) begin
			item_hs <= 1'b0;
		end else begin
			item_hs <= item_bus.valid && item_bus.ready;
			if (res_bus.valid && res_bus.ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 30)
						$display("%0t: unexpected result, expected none actual accepted %0d fired %0d",
							$time, res_bus.accepted, res_bus.fired);
				end else begin
					want = expected_results.pop_front();
					check_field("accepted", want.accepted, res_bus.accepted);
					check_field("fired", want.fired, res_bus.fired);
					check_field("fired_index", want.fired_index, res_bus.fired_index);
					check_field("fired_deferred", want.fired_deferred, res_bus.fired_deferred);
					check_field("sequence_done", want.sequence_done, res_bus.sequence_done);
					check_field("busy_res", want.busy_res, res_bus.busy_res);
					check_field("pending_valid", want.pending_valid, res_bus.pending_valid);
					check_field("pending_index", want.pending_index, res_bus.pending_index);
				end
			end
			if (cfg_bus.valid && cfg_bus.ready)
				seq_count = cfg_bus.countdown_count;
			if (item_bus.valid && item_bus.ready) begin
				c.op    = item_bus.opcode;
				c.idx   = item_bus.entry_index;
				c.ovf   = item_bus.load_overflows;
				c.ticks = item_bus.load_ticks;
				c.defer = item_bus.load_deferred;
				expected_results.push_back(predict_timer(c));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	task automatic queue_cmd(input logic [OP_W-1:0] op, input int idx, input int ovf,
		input int ticks, input logic defer);
		timer_cmd_t c;
		c.op    = op;
		c.idx   = IDX_W'(idx);
		c.ovf   = TBL_D_W'(ovf);
		c.ticks = TBL_D_W'(ticks);
		c.defer = defer;
		cmd_backlog.push_back(c);
		items_queued++;
	endtask

	// stray command with small table values; reset only when allowed
	task automatic queue_noise(input logic allow_reset);
		logic [OP_W-1:0] op;
		op = OP_W'($urandom_range(7));
		if (op == OP_RESET && !allow_reset)
			op = OP_TAKE;
		queue_cmd(op, $urandom_range(7), 0, $urandom_range(5), $urandom_range(1));
	endtask

	// wait until every queued transaction has been sent and answered
	task automatic wait_idle();
		while (cmd_backlog.size() != 0 || item_bus.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_count(input int value);
		@(negedge clk);
		cfg_bus.valid           <= 1'b1;
		cfg_bus.countdown_count <= CFG_W'(value);
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// drain, and tick out any sequence still running so config can change
	task automatic settle();
		int tries;
		tries = 0;
		wait_idle();
		while (seq_running) begin
			if (tries < 8)
				repeat (8) queue_cmd(OP_TICK, 0, 0, 0, 1'b0);
			else
				queue_cmd(OP_RESET, 0, 0, 0, 1'b0);
			tries++;
			wait_idle();
		end
	endtask

	function automatic int pick_count();
		int v;
		if ($urandom_range(99) < 85)
			return $urandom_range(1, MAX_ENTRIES);
		v = $urandom_range(7);
		return (v == 0) ? 0 : MAX_ENTRIES + v;
	endfunction

	// load entries in random order, start, tick through, then collect
	task automatic run_sequence_episode();
		int order [MAX_ENTRIES];
		int n, j, tmp, spins, t;
		n = pick_count();
		write_count(n);
		for (int k = 0; k < MAX_ENTRIES; k++)
			order[k] = k;
		for (int k = MAX_ENTRIES - 1; k > 0; k--) begin
			j = $urandom_range(k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		spins = 0;
		for (int k = 0; k < MAX_ENTRIES; k++) begin
			if (order[k] < n) begin
				t = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
				spins += (t == 0) ? 1 : t;
				queue_cmd(OP_LOAD, order[k], 0, t, $urandom_range(1));
				if ($urandom_range(9) == 0)
					queue_noise(1'b0);
			end
		end
		queue_cmd(OP_START, 0, 0, 0, 1'b0);
		spins += $urandom_range(3);
		for (int k = 0; k < spins; k++) begin
			if ($urandom_range(99) < 12)
				queue_noise(1'b0);
			queue_cmd(OP_TICK, 0, 0, 0, 1'b0);
		end
		if ($urandom_range(1))
			queue_cmd(OP_TAKE, 0, 0, 0, 1'b0);
	endtask

	// full-range table contents, a few ticks, then a reset opcode mid-run
	task automatic run_abort_episode();
		int n;
		n = $urandom_range(1, MAX_ENTRIES);
		write_count(n);
		for (int k = 0; k < n; k++)
			queue_cmd(OP_LOAD, k, $urandom_range(65535), $urandom_range(65535),
				$urandom_range(1));
		queue_cmd(OP_START, 0, 0, 0, 1'b0);
		repeat ($urandom_range(30)) begin
			if ($urandom_range(99) < 15)
				queue_noise(1'b0);
			queue_cmd(OP_TICK, 0, 0, 0, 1'b0);
		end
		queue_cmd(OP_RESET, 0, 0, 0, 1'b0);
		if ($urandom_range(1))
			queue_cmd(OP_START, 0, 0, 0, 1'b0);
		queue_cmd(OP_TAKE, 0, 0, 0, 1'b0);
	endtask

	task automatic run_noise_episode();
		write_count($urandom_range(15));
		repeat ($urandom_range(10, 20)) queue_noise(1'b1);
	endtask

	initial begin
		int kind;
		arst_n                  = 1'b0;
		item_bus.valid          = 1'b0;
		item_bus.opcode         = OP_TICK;
		item_bus.entry_index    = '0;
		item_bus.load_overflows = '0;
		item_bus.load_ticks     = '0;
		item_bus.load_deferred  = 1'b0;
		res_bus.ready           = 1'b0;
		cfg_bus.valid           = 1'b0;
		cfg_bus.countdown_count = '0;
		clear_timer(1'b1);
		for (int i = 0; i < MAX_ENTRIES; i++)
			tbl_defer[i] = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// nothing configured: start refused, empty take, no-op opcodes, idle tick, load of entry 7
		queue_cmd(OP_START, 0, 0, 0, 1'b0);
		queue_cmd(OP_TAKE, 0, 0, 0, 1'b0);
		queue_cmd(OP_UNUSED5, 0, 0, 0, 1'b0);
		queue_cmd(OP_UNUSED7, 0, 0, 0, 1'b0);
		queue_cmd(OP_TICK, 0, 0, 0, 1'b0);
		queue_cmd(OP_LOAD, 7, 16'hFFFF, 16'hFFFF, 1'b0);
		wait_idle();

		// count above the table size: start refused
		write_count(15);
		queue_cmd(OP_START, 0, 0, 0, 1'b0);
		wait_idle();

		// two deferred entries: zero target acts as one, newer pending wins,
		// refused start and load while running, reset mid-run clears the count
		write_count(2);
		queue_cmd(OP_LOAD, 0, 0, 0, 1'b1);
		queue_cmd(OP_LOAD, 1, 0, 2, 1'b1);
		queue_cmd(OP_START, 0, 0, 0, 1'b0);
		queue_cmd(OP_START, 0, 0, 0, 1'b0);
		queue_cmd(OP_LOAD, 2, 0, 1, 1'b0);
		repeat (3) queue_cmd(OP_TICK, 0, 0, 0, 1'b0);
		queue_cmd(OP_TAKE, 0, 0, 0, 1'b0);
		queue_cmd(OP_TAKE, 0, 0, 0, 1'b0);
		queue_cmd(OP_UNUSED6, 0, 0, 0, 1'b0);
		queue_cmd(OP_START, 0, 0, 0, 1'b0);
		queue_cmd(OP_TICK, 0, 0, 0, 1'b0);
		queue_cmd(OP_RESET, 0, 0, 0, 1'b0);
		queue_cmd(OP_START, 0, 0, 0, 1'b0);
		settle();

		// random episodes across three idle mixes
		while (items_queued < RANDOM_ITEMS + 25) begin
			if (items_queued < 525) begin
				send_idle_pct = 33;
				recv_idle_pct = 78;
			end else if (items_queued < 1025) begin
				send_idle_pct = 78;
				recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			kind = $urandom_range(99);
			if (kind < 70)
				run_sequence_episode();
			else if (kind < 85)
				run_abort_episode();
			else
				run_noise_episode();
			settle();
		end

		// back-to-back burst through one deferred entry; output held off meanwhile
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_count(1);
		queue_cmd(OP_LOAD, 0, 0, BURST_TICKS, 1'b1);
		queue_cmd(OP_START, 0, 0, 0, 1'b0);
		repeat (BURST_TICKS + 5) queue_cmd(OP_TICK, 0, 0, 0, 1'b0);
		queue_cmd(OP_TAKE, 0, 0, 0, 1'b0);
		hold_requests++;
		wait_idle();

		repeat (10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ countdown_sequence_timer_top.f @@
src/cst_pkg.sv
src/cst_if.sv
src/cst_ctl.sv
src/cst_dp.sv
src/countdown_sequence_timer_top.sv
src/cst_checker.sv
verif/testbench.sv
